FILE: sv/pga_pkg.sv
// shared types and constants of the point group averager
`default_nettype none

package pga_pkg;

    localparam int unsigned GS_W = 8;
    localparam logic [GS_W-1:0] GROUP_SIZE_RESET = 8'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic load_out;
    } pga_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic emit;
        logic out_free;
    } pga_sts_t;

endpackage

`default_nettype wire

FILE: sv/point_group_averager_core.sv
// Point group averager: sums contour points and emits one averaged point per group.
//
// Input channel s_*: one word is a point (s_point_x, s_point_y) and s_last_point,
// which marks the end of a contour. Result channel m_*: the truncated average
// (m_avg_x, m_avg_y) and m_points_averaged, the number of points behind it.
// Configuration channel cfg_*: cfg_wdata sets the group size; write it only
// while the block is idle. Zero acts as one.
// A point that completes no group leaves s_ready high.
// A point that completes a group, or ends a contour with a remainder larger
// than half a group, starts two COORD_BITS-step dividers, one quotient bit per
// cycle: the result word is loaded into the result register after the last step,
// and s_ready is low meanwhile. The divider length sets the rate.
// The result register holds one word; if it is still unread when the next
// divide finishes, the block waits with s_ready low until m_ready takes it.
// A shorter remainder is dropped at the last point; the group clears either way.
// Reset (aresetn low, synchronous) empties the sums and the result register and
// sets the group size to 4.
`default_nettype none

module point_group_averager_core #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [pga_pkg::GS_W-1:0]  cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [COORD_BITS-1:0]     s_point_x,
    input  wire logic [COORD_BITS-1:0]     s_point_y,
    input  wire logic                      s_last_point,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic      [COORD_BITS-1:0]     m_avg_x,
    output logic      [COORD_BITS-1:0]     m_avg_y,
    output logic      [pga_pkg::GS_W-1:0]  m_points_averaged
);

    pga_pkg::pga_cmd_t cmd;
    pga_pkg::pga_sts_t sts;

    assign cfg_ready = 1'b1;

    pga_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pga_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_wdata         (cfg_wdata),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .s_last_point      (s_last_point),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_avg_x           (m_avg_x),
        .m_avg_y           (m_avg_y),
        .m_points_averaged (m_points_averaged)
    );

endmodule

`default_nettype wire

FILE: sv/pga_divider.sv
// restoring divider, one quotient bit per step, for a sum over an 8-bit count
`default_nettype none

module pga_divider #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         load,
    input  wire logic                         step,
    input  wire logic [COORD_BITS+7:0]        dividend,
    input  wire logic [pga_pkg::GS_W-1:0]     divisor,
    output logic      [COORD_BITS-1:0]        quotient
);

    localparam int unsigned GW = pga_pkg::GS_W;

    logic [GW-1:0]         rem_reg, rem_next;
    logic [COORD_BITS-1:0] dvd_reg, dvd_next;
    logic [GW-1:0]         div_reg, div_next;
    logic [GW:0]           trial;
    logic [GW:0]           diff;
    logic                  qbit;

    // remainder stays below the divisor since the quotient fits in COORD_BITS
    always_comb begin
        trial    = {rem_reg, dvd_reg[COORD_BITS-1]};
        diff     = trial - {1'b0, div_reg};
        // trial is below twice the divisor, so the top bit of diff is the borrow
        qbit     = !diff[GW];
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        div_next = div_reg;
        if (load) begin
            rem_next = dividend[COORD_BITS+GW-1:COORD_BITS];
            dvd_next = dividend[COORD_BITS-1:0];
            div_next = divisor;
        end else if (step) begin
            rem_next = qbit ? diff[GW-1:0] : trial[GW-1:0];
            dvd_next = {dvd_reg[COORD_BITS-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign quotient = dvd_reg;

endmodule

`default_nettype wire

FILE: sv/pga_datapath.sv
// sums, point count, group size register, dividers and result register
`default_nettype none

module pga_datapath #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pga_pkg::pga_cmd_t           cmd,
    output pga_pkg::pga_sts_t                sts,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [pga_pkg::GS_W-1:0]    cfg_wdata,
    input  wire logic [COORD_BITS-1:0]       s_point_x,
    input  wire logic [COORD_BITS-1:0]       s_point_y,
    input  wire logic                        s_last_point,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [COORD_BITS-1:0]       m_avg_x,
    output logic      [COORD_BITS-1:0]       m_avg_y,
    output logic      [pga_pkg::GS_W-1:0]    m_points_averaged
);

    localparam int unsigned GW    = pga_pkg::GS_W;
    localparam int unsigned SUM_W = COORD_BITS + GW;

    logic [GW-1:0]         gs_reg, gs_next;
    logic [SUM_W-1:0]      sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]      sum_y_reg, sum_y_next;
    logic [GW-1:0]         cnt_reg, cnt_next;
    logic [GW-1:0]         n_reg, n_next;
    logic                  m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0] avg_x_reg, avg_y_reg;
    logic [GW-1:0]         pts_reg;

    logic [SUM_W-1:0]      add_x, add_y;
    logic [GW-1:0]         cnt_inc;
    logic [GW-1:0]         gs_eff;
    logic                  emit;
    logic [COORD_BITS-1:0] quo_x, quo_y;

    // group size zero behaves as one
    always_comb begin
        gs_eff  = (gs_reg == '0) ? GW'(1) : gs_reg;
        add_x   = sum_x_reg + SUM_W'(s_point_x);
        add_y   = sum_y_reg + SUM_W'(s_point_y);
        cnt_inc = cnt_reg + GW'(1);
        emit    = (cnt_inc != '0) &&
                  ((cnt_inc >= gs_eff) || (s_last_point && (cnt_inc > (gs_eff >> 1))));
    end

    assign sts.emit     = emit;
    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        gs_next    = gs_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        if (cfg_valid && cfg_ready) begin
            gs_next = cfg_wdata;
        end
        if (cmd.accept) begin
            if (emit || s_last_point) begin
                sum_x_next = '0;
                sum_y_next = '0;
                cnt_next   = '0;
            end else begin
                sum_x_next = add_x;
                sum_y_next = add_y;
                cnt_next   = cnt_inc;
            end
        end
        if (cmd.div_start) begin
            n_next = cnt_inc;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gs_reg      <= pga_pkg::GROUP_SIZE_RESET;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            gs_reg      <= gs_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;
        if (cmd.load_out) begin
            avg_x_reg <= quo_x;
            avg_y_reg <= quo_y;
            pts_reg   <= n_reg;
        end
    end

    pga_divider #(
        .COORD_BITS (COORD_BITS)
    ) u_div_x (
        .aclk     (aclk),
        .load     (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (add_x),
        .divisor  (cnt_inc),
        .quotient (quo_x)
    );

    pga_divider #(
        .COORD_BITS (COORD_BITS)
    ) u_div_y (
        .aclk     (aclk),
        .load     (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (add_y),
        .divisor  (cnt_inc),
        .quotient (quo_y)
    );

    assign m_valid           = m_valid_reg;
    assign m_avg_x           = avg_x_reg;
    assign m_avg_y           = avg_y_reg;
    assign m_points_averaged = pts_reg;

`ifndef ASSERT_OFF
    // the last point of a contour always leaves an empty group
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && s_last_point |=> cnt_reg == '0)
        else $error("group not cleared after last point");

    // a full count of 255 is always emitted, never held
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '1)
        else $error("point count reached its limit");

    a_pts_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> pts_reg != '0)
        else $error("result word averages zero points");
`endif

endmodule

`default_nettype wire

FILE: sv/pga_ctrl.sv
// controller: accepts points, sequences the divide, hands off the result
`default_nettype none

module pga_ctrl #(
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pga_pkg::pga_sts_t sts,
    output pga_pkg::pga_cmd_t      cmd
);

    localparam int unsigned STEP_W = $clog2(COORD_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        s_ready       = 1'b0;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && sts.emit) begin
                    cmd.div_start = 1'b1;
                    step_next     = STEP_LAST;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // wait here while the previous result word is still held
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef ASSERT_OFF
    a_emit_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && sts.emit |=> state_reg == S_DIV)
        else $error("emitting word did not start a divide");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && step_reg == '0 |=> state_reg == S_DONE)
        else $error("divide did not finish after its last step");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

FILE: dv/point_group_averager_core_test.sv
// self-checking testbench of the point group averager: directed table, then random contours
`default_nettype none

module point_group_averager_core_test;

    localparam int unsigned GS_W = pga_pkg::GS_W;
    localparam int unsigned CB = 12;
    localparam int unsigned SUM_W = CB + 8;
    localparam int unsigned SETTLE_CYCLES = CB + 8;
    localparam int unsigned ITEMS_PER_PHASE = 500;

    typedef struct packed {
        logic [CB-1:0]   ax;
        logic [CB-1:0]   ay;
        logic [GS_W-1:0] n;
    } avg_word_t;

    typedef enum logic [1:0] {
        ROW_POINT,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [CB-1:0]   x;
        logic [CB-1:0]   y;
        logic            last;
        logic [GS_W-1:0] cfg;
        avg_word_t       want;
    } stim_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [GS_W-1:0] cfg_wdata = '0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic [CB-1:0]   s_point_x = '0;
    logic [CB-1:0]   s_point_y = '0;
    logic            s_last_point = 1'b0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic [CB-1:0]   m_avg_x;
    logic [CB-1:0]   m_avg_y;
    logic [GS_W-1:0] m_points_averaged;

    point_group_averager_core #(
        .COORD_BITS(CB)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_point_x         (s_point_x),
        .s_point_y         (s_point_y),
        .s_last_point      (s_last_point),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_avg_x           (m_avg_x),
        .m_avg_y           (m_avg_y),
        .m_points_averaged (m_points_averaged)
    );

    // predictor state
    logic [GS_W-1:0]  group_size_q;
    logic [SUM_W-1:0] acc_x;
    logic [SUM_W-1:0] acc_y;
    logic [GS_W-1:0]  acc_count;

    avg_word_t expected_avgs[$];
    stim_row_t dir_rows[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned points_sent = 0;
    int unsigned averages_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatches = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // accumulate one point, report whether it closes a group
    function automatic bit accumulate_point(input logic [CB-1:0] px, input logic [CB-1:0] py,
                                            input logic last, output avg_word_t w);
        logic [GS_W-1:0] gs;
        bit              emit;
        gs = (group_size_q == '0) ? GS_W'(1) : group_size_q;
        acc_x = acc_x + SUM_W'(px);
        acc_y = acc_y + SUM_W'(py);
        acc_count = acc_count + 1'b1;
        w = '0;
        if (acc_count >= gs)
            emit = 1'b1;
        else if (last)
            emit = acc_count > (gs >> 1);
        else
            emit = 1'b0;
        if (emit && acc_count != '0) begin
            w.ax = CB'(acc_x / SUM_W'(acc_count));
            w.ay = CB'(acc_y / SUM_W'(acc_count));
            w.n  = acc_count;
            acc_x = '0;
            acc_y = '0;
            acc_count = '0;
            return 1'b1;
        end
        if (last) begin
            acc_x = '0;
            acc_y = '0;
            acc_count = '0;
        end
        return 1'b0;
    endfunction

    function automatic stim_row_t make_row(input row_kind_t kind, input int x, input int y,
                                           input bit last, input int cfg,
                                           input int ex, input int ey, input int en);
        stim_row_t r;
        r.kind = kind;
        r.x = CB'(x);
        r.y = CB'(y);
        r.last = last;
        r.cfg = GS_W'(cfg);
        r.want.ax = CB'(ex);
        r.want.ay = CB'(ey);
        r.want.n = GS_W'(en);
        return r;
    endfunction

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {CB{1'b1}};
            default: return CB'($urandom_range(0, (1 << CB) - 1));
        endcase
    endfunction

    function automatic logic [GS_W-1:0] pick_group_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 7)
            return {GS_W{1'b1}};
        else if (r < 12)
            return GS_W'($urandom_range(9, 64));
        else if (r < 22)
            return GS_W'(1);
        else
            return GS_W'($urandom_range(2, 8));
    endfunction

    task automatic send_point(input logic [CB-1:0] px, input logic [CB-1:0] py,
                              input logic last, input bit use_typed, input avg_word_t typed);
        avg_word_t w;
        bit        hit;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_point_x <= px;
        s_point_y <= py;
        s_last_point <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        points_sent++;
        hit = accumulate_point(px, py, last, w);
        if (use_typed)
            expected_avgs = {expected_avgs, typed};
        else if (hit)
            expected_avgs = {expected_avgs, w};
    endtask

    // quiet the input and let every pending average come out
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_avgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_group_size(input logic [GS_W-1:0] v);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        group_size_q = v;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            averages_seen++;
            if (expected_avgs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected average word: x=%0d y=%0d n=%0d",
                             m_avg_x, m_avg_y, m_points_averaged);
            end else begin
                avg_word_t w;
                w = expected_avgs.pop_front();
                if (m_avg_x !== w.ax || m_avg_y !== w.ay || m_points_averaged !== w.n) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("average %0d: expected %0d,%0d n=%0d, got %0d,%0d n=%0d",
                                 averages_seen, w.ax, w.ay, w.n,
                                 m_avg_x, m_avg_y, m_points_averaged);
                end
            end
        end
    end

    initial begin
        int unsigned target;
        int unsigned len;
        int unsigned gs;
        bit          noisy;
        logic        last;

        group_size_q = pga_pkg::GROUP_SIZE_RESET;
        acc_x = '0;
        acc_y = '0;
        acc_count = '0;

        // directed table
        dir_rows = {dir_rows, make_row(ROW_POINT, 4095, 4095, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 4095, 4095, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 4095, 4095, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_TYPED, 4095, 4095, 0, 0, 4095, 4095, 4)};
        // remainder over half a group is emitted
        dir_rows = {dir_rows, make_row(ROW_POINT, 4095, 0, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 0, 4095, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 1, 2, 1, 0, 0, 0, 0)};
        // short remainder is dropped
        dir_rows = {dir_rows, make_row(ROW_POINT, 7, 9, 1, 0, 0, 0, 0)};
        // zero group size behaves as one
        dir_rows = {dir_rows, make_row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_TYPED, 0, 0, 0, 0, 0, 0, 1)};
        dir_rows = {dir_rows, make_row(ROW_TYPED, 4095, 1, 1, 0, 4095, 1, 1)};
        dir_rows = {dir_rows, make_row(ROW_CFG, 0, 0, 0, 255, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 4095, 4095, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 4095, 4095, 1, 0, 0, 0, 0)};
        // group size lowered below the running count
        dir_rows = {dir_rows, make_row(ROW_CFG, 0, 0, 0, 8, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 10, 20, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 30, 40, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 50, 60, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_CFG, 0, 0, 0, 2, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_TYPED, 70, 80, 0, 0, 40, 50, 4)};
        // full group that lands on the last point
        dir_rows = {dir_rows, make_row(ROW_CFG, 0, 0, 0, 3, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 1, 1, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 2, 2, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_TYPED, 3, 3, 1, 0, 2, 2, 3)};
        dir_rows = {dir_rows, make_row(ROW_CFG, 0, 0, 0, 5, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 0, 1, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 0, 0, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, make_row(ROW_POINT, 4095, 4095, 1, 0, 0, 0, 0)};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 77;
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    write_group_size(dir_rows[i].cfg);
                end
                ROW_TYPED: begin
                    send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                               1'b1, dir_rows[i].want);
                end
                default: begin
                    send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last, 1'b0, '0);
                end
            endcase
        end

        // random contours in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 77 : 0;
            recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 32 : 0;
            write_group_size(pick_group_size());
            target = points_sent + ITEMS_PER_PHASE;
            while (points_sent < target) begin
                if ($urandom_range(0, 4) == 0)
                    write_group_size(pick_group_size());
                gs = (group_size_q == '0) ? 1 : group_size_q;
                len = $urandom_range(1, gs + gs / 2 + 1);
                noisy = ($urandom_range(0, 9) == 0);
                for (int unsigned i = 0; i < len; i++) begin
                    // shrink the group to no more than what has already piled up
                    if (acc_count != '0 && $urandom_range(0, 49) == 0)
                        write_group_size(GS_W'($urandom_range(1, acc_count)));
                    last = noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1);
                    send_point(rand_coord(), rand_coord(), last, 1'b0, '0);
                end
            end
        end

        settle();
        $display("sent %0d points over %0d group size writes, checked %0d averages",
                 points_sent, cfg_writes, averages_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
